// ----- rtl/apr_pkg.sv -----
// Shared types and constants for the average predictor plane reconstruct unit.
package apr_pkg;

    localparam int PIX_W          = 8;
    localparam int PW_W           = 12;
    localparam int PH_W           = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int RESET_WIDTH    = 2048;
    localparam int RESET_HEIGHT   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic                  wr;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_req_t;

    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last;
    } pos_flags_t;

endpackage

// ----- rtl/apr_line_buf.sv -----
// Line buffer memory: one write port, one registered read port.
module apr_line_buf
    import apr_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEF_MAX_WIDTH)
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [PIX_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/apr_position.sv -----
// Plane size registers and raster position counters.
module apr_position
    import apr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_req_t                      cfg,
    input  logic                          advance,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output pos_flags_t                    flags,
    output logic                          restart
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

    logic [WW-1:0] eff_w_reg;
    logic [WW-1:0] eff_w_next;
    logic [HW-1:0] eff_h_reg;
    logic [HW-1:0] eff_h_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [PW_W-1:0] raw_w;
    logic [PH_W-1:0] raw_h;
    logic          row_end;
    logic          plane_end;

    assign raw_w   = cfg.data[PW_W-1:0];
    assign raw_h   = cfg.data[PH_W-1:0];
    assign restart = cfg.wr && (cfg.idx == REG_PLANE_WIDTH || cfg.idx == REG_PLANE_HEIGHT);

    assign row_end   = (WW'(col_reg) + WW'(1)) >= eff_w_reg;
    assign plane_end = (HW'(row_reg) + HW'(1)) >= eff_h_reg;

    always_comb
    begin
        eff_w_next = eff_w_reg;
        eff_h_next = eff_h_reg;
        if (cfg.wr && cfg.idx == REG_PLANE_WIDTH)
        begin
            priority if (raw_w == '0)
            begin
                eff_w_next = WW'(1);
            end
            else if (32'(raw_w) > 32'(MAX_WIDTH))
            begin
                eff_w_next = WW'(MAX_WIDTH);
            end
            else
            begin
                eff_w_next = WW'(raw_w);
            end
        end
        if (cfg.wr && cfg.idx == REG_PLANE_HEIGHT)
        begin
            priority if (raw_h == '0)
            begin
                eff_h_next = HW'(1);
            end
            else if (32'(raw_h) > 32'(MAX_HEIGHT))
            begin
                eff_h_next = HW'(MAX_HEIGHT);
            end
            else
            begin
                eff_h_next = HW'(raw_h);
            end
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (advance)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = plane_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg <= WW'(RST_W);
            eff_h_reg <= HW'(RST_H);
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            eff_w_reg <= eff_w_next;
            eff_h_reg <= eff_h_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    assign col             = col_reg;
    assign flags.first_row = (row_reg == '0);
    assign flags.first_col = (col_reg == '0);
    assign flags.last      = row_end && plane_end;

endmodule

// ----- rtl/average_predictor_plane_reconstruct_unit.sv -----
// Top level of the average predictor plane reconstruct unit.
// Takes one residual byte per cycle in raster order and returns one reconstructed byte per
// item via the p1 and output registers; a steady stream runs at one item per clock, limited
// only by out_ready. The line buffer has one read port (issued at acceptance) and one write
// port (used when the result is formed); a sample that reads the entry written in the cycle of
// its acceptance takes the value from the left register instead. A write of plane_width
// (index 0) or plane_height (index 1) restarts the plane; the line buffer keeps its contents.
module average_predictor_plane_reconstruct_unit
    import apr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      residual,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      pixel_value,
    output logic                  last_of_plane
);

    localparam int CW = $clog2(MAX_WIDTH);

    cfg_req_t   cfg;
    pos_flags_t cur_flags;
    logic [CW-1:0] cur_col;
    logic       restart;
    logic       in_accept;
    logic       p1_move;

    logic          p1_valid_reg;
    logic [PIX_W-1:0] p1_res_reg;
    logic [CW-1:0] p1_slot_reg;
    pos_flags_t    p1_flags_reg;
    logic          p1_fwd_reg;

    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] rd_data;
    logic [PIX_W-1:0] up;
    logic [PIX_W:0]   sum;
    logic [PIX_W-1:0] pred;
    logic [PIX_W-1:0] val;

    logic             out_valid_reg;
    logic [PIX_W-1:0] pixel_reg;
    logic             last_reg;

    assign cfg_ready = 1'b1;
    assign cfg.wr    = cfg_valid && cfg_ready;
    assign cfg.idx   = cfg_index;
    assign cfg.data  = cfg_data;

    assign p1_move   = p1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !p1_valid_reg || p1_move;
    assign in_accept = in_valid && in_ready;

    apr_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (in_accept),
        .col     (cur_col),
        .flags   (cur_flags),
        .restart (restart)
    );

    apr_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (cur_col),
        .rd_data (rd_data),
        .wr_en   (p1_move),
        .wr_addr (p1_slot_reg),
        .wr_data (val)
    );

    // Reconstruct from up and left
    assign up  = p1_fwd_reg ? left_reg : rd_data;
    assign sum = {1'b0, up} + {1'b0, left_reg};

    always_comb
    begin
        priority if (p1_flags_reg.first_row && p1_flags_reg.first_col)
        begin
            pred = '0;
        end
        else if (p1_flags_reg.first_row)
        begin
            pred = left_reg;
        end
        else if (p1_flags_reg.first_col)
        begin
            pred = up;
        end
        else
        begin
            pred = sum[PIX_W:1];
        end
    end

    assign val = (p1_flags_reg.first_row && p1_flags_reg.first_col) ? p1_res_reg
                                                                     : pred - p1_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_move)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (restart)
            begin
                left_reg <= '0;
            end
            else if (p1_move)
            begin
                left_reg <= val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p1_res_reg   <= residual;
            p1_slot_reg  <= cur_col;
            p1_flags_reg <= cur_flags;
            p1_fwd_reg   <= p1_move && (p1_slot_reg == cur_col);
        end
        if (p1_move)
        begin
            pixel_reg <= val;
            last_reg  <= p1_flags_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_value   = pixel_reg;
    assign last_of_plane = last_reg;

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> p1_valid_reg)
        else $error("accepted item did not enter the compute stage");

    a_move_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        p1_move |=> out_valid)
        else $error("computed item did not reach the output register");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (cur_col == '0) && (left_reg == '0) && cur_flags.first_row)
        else $error("register write did not restart the plane");
`endif

endmodule
